@@ rtl/cde_pkg.sv @@
// Package for the circular deque engine: operation and status codes, field widths,
// and the request struct passed from the index controller to the slot memory.
// No dependencies.
package cde_pkg;

	// Widths fixed by the beat format.
	localparam int unsigned MODE_W   = 3;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned CNT_W    = 5;

	// Operation codes carried in the mode field. Codes above PEEK act as a peek.
	localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_INS_BACK  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ERA_FRONT = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ERA_BACK  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_PEEK      = 3'd4;

	// Status codes reported with every result.
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// Slot memory access for one operation. Indices are kept at count width
	// and resized to the memory address width inside the memory.
	typedef struct packed {
		logic             ren;
		logic             we;
		logic [CNT_W-1:0] waddr;
		logic [CNT_W-1:0] raddr_front;
		logic [CNT_W-1:0] raddr_back;
	} mem_req_t;

	// Outcome of one operation as known in the cycle it is accepted.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [CNT_W-1:0]    count;
	} step_res_t;

endpackage

@@ rtl/cde_ram.sv @@
// Slot memory of the circular deque engine: one write port and two registered
// read ports. Uses cde_pkg for the request struct.
module cde_ram #(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned WORD_WIDTH = 32
) (
	input  logic                  clk,
	input  cde_pkg::mem_req_t     req,
	input  logic [WORD_WIDTH-1:0] wdata,
	output logic [WORD_WIDTH-1:0] rdata_front,
	output logic [WORD_WIDTH-1:0] rdata_back
);

	localparam int unsigned AW = $clog2(DEPTH);

	logic [WORD_WIDTH-1:0] mem [DEPTH];

	// Reads return the old contents on an address collision; the caller forwards.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[AW'(req.waddr)] <= wdata;
		end
		if (req.ren) begin
			rdata_front <= mem[AW'(req.raddr_front)];
			rdata_back  <= mem[AW'(req.raddr_back)];
		end
	end

endmodule

@@ rtl/cde_ctrl.sv @@
// Index controller of the circular deque engine: capacity register, front and rear
// indices, occupancy, and the slot memory request for each operation. Uses cde_pkg.
module cde_ctrl #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cde_pkg::CNT_W-1:0]     cfg_wdata,
	input  logic                          step,
	input  logic [cde_pkg::MODE_W-1:0]    mode,
	output cde_pkg::mem_req_t             req,
	output cde_pkg::step_res_t            res
);

	localparam int unsigned CW      = cde_pkg::CNT_W;
	localparam int unsigned CAP_RST = (DEPTH < 16) ? DEPTH : 16;

	logic [CW-1:0] cap_q;
	logic [CW-1:0] front_q, rear_q, occ_q;
	logic [CW-1:0] front_n, rear_n, occ_n;
	logic [cde_pkg::STATUS_W-1:0] status;
	logic full, empty;
	logic [CW-1:0] cap_eff;

	function automatic logic [CW-1:0] idx_inc(input logic [CW-1:0] i, input logic [CW-1:0] c);
		logic [CW:0] s;
		s = {1'b0, i} + (CW+1)'(1);
		return (s >= {1'b0, c}) ? '0 : s[CW-1:0];
	endfunction

	function automatic logic [CW-1:0] idx_dec(input logic [CW-1:0] i, input logic [CW-1:0] c);
		return (i == '0) ? c - CW'(1) : i - CW'(1);
	endfunction

	// A written capacity of zero means one slot; anything above the store means all of it.
	always_comb begin
		if (cfg_wdata == '0) begin
			cap_eff = CW'(1);
		end else if (32'(cfg_wdata) > DEPTH) begin
			cap_eff = CW'(DEPTH);
		end else begin
			cap_eff = cfg_wdata;
		end
	end

	assign full  = (occ_q >= cap_q);
	assign empty = (occ_q == '0);

	always_comb begin
		front_n = front_q;
		rear_n  = rear_q;
		occ_n   = occ_q;
		status  = cde_pkg::ST_DONE;
		req.we  = 1'b0;
		req.waddr = '0;
		case (mode)
			cde_pkg::MODE_INS_FRONT: begin
				if (full) begin
					status = cde_pkg::ST_FULL;
				end else begin
					front_n   = idx_dec(front_q, cap_q);
					req.we    = step;
					req.waddr = front_n;
					occ_n     = occ_q + CW'(1);
				end
			end
			cde_pkg::MODE_INS_BACK: begin
				if (full) begin
					status = cde_pkg::ST_FULL;
				end else begin
					req.we    = step;
					req.waddr = rear_q;
					rear_n    = idx_inc(rear_q, cap_q);
					occ_n     = occ_q + CW'(1);
				end
			end
			cde_pkg::MODE_ERA_FRONT: begin
				if (empty) begin
					status = cde_pkg::ST_EMPTY;
				end else begin
					front_n = idx_inc(front_q, cap_q);
					occ_n   = occ_q - CW'(1);
				end
			end
			cde_pkg::MODE_ERA_BACK: begin
				if (empty) begin
					status = cde_pkg::ST_EMPTY;
				end else begin
					rear_n = idx_dec(rear_q, cap_q);
					occ_n  = occ_q - CW'(1);
				end
			end
			default: begin
			end
		endcase
		req.ren         = step;
		req.raddr_front = front_n;
		req.raddr_back  = idx_dec(rear_n, cap_q);
		res.status      = status;
		res.count       = occ_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CW'(CAP_RST);
			front_q <= '0;
			rear_q  <= '0;
			occ_q   <= '0;
		end else if (cfg_we) begin
			cap_q   <= cap_eff;
			front_q <= '0;
			rear_q  <= '0;
			occ_q   <= '0;
		end else if (step) begin
			front_q <= front_n;
			rear_q  <= rear_n;
			occ_q   <= occ_n;
		end
	end

endmodule

@@ rtl/circular_deque_engine.sv @@
// Circular deque engine: a double-ended queue of WORD_WIDTH-bit words in a circular
// slot memory whose indices wrap at the programmed capacity. Each input beat carries
// one operation (insert front, insert back, erase front, erase back, or peek) and
// produces exactly one output beat with the status, the front and back words (zero
// when empty), the element count and an empty flag. The block sustains one beat per
// clock while the result stream is not stalled: indices and count update in the accept
// cycle, the slot memory is written and read at the new front and back in that same
// edge, and the result passes the read stage and then the output register before
// m_tvalid rises. s_tready drops only while both the read stage and the output
// register hold results that the downstream side has not taken. Writing capacity
// empties the deque; do so only while no beat is in flight.
//
// Depends on cde_pkg, cde_ctrl and cde_ram.
module circular_deque_engine #(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned WORD_WIDTH = 32,
	// Beat widths, rounded up to whole bytes.
	localparam int unsigned IN_W  = ((cde_pkg::MODE_W + WORD_WIDTH + 7) / 8) * 8,
	localparam int unsigned OUT_W = ((cde_pkg::STATUS_W + 2 * WORD_WIDTH +
		cde_pkg::CNT_W + 1 + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Capacity register: written whenever cfg_we is high.
	input  logic                          cfg_we,
	input  logic [cde_pkg::CNT_W-1:0]     cfg_wdata,
	// Operation stream.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [IN_W-1:0]               s_tdata,   // mode, value, zero pad
	// Result stream.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [OUT_W-1:0]              m_tdata    // status, front_value, back_value,
	                                                 // count, is_empty, zero pad
);

	localparam int unsigned MW    = cde_pkg::MODE_W;
	localparam int unsigned SW    = cde_pkg::STATUS_W;
	localparam int unsigned CW    = cde_pkg::CNT_W;

	logic                  accept;
	logic                  adv;
	cde_pkg::mem_req_t     req;
	cde_pkg::step_res_t    res;
	logic [WORD_WIDTH-1:0] rdata_front, rdata_back;

	// Read stage: what is known in the accept cycle, waiting for the memory data.
	logic                  v_s1;
	cde_pkg::step_res_t    res_s1;
	logic                  fwd_front_s1, fwd_back_s1;
	logic [WORD_WIDTH-1:0] wdata_s1;

	// Output register.
	logic                  out_v_q;
	logic [SW-1:0]         status_q;
	logic [WORD_WIDTH-1:0] front_q, back_q;
	logic [CW-1:0]         count_q;

	logic [WORD_WIDTH-1:0] front_val, back_val;

	// The read stage moves on whenever the output register is free or being emptied.
	// The memory read data only changes on an accept, so a stalled read stage keeps it.
	assign adv      = v_s1 && (!out_v_q || m_tready);
	assign s_tready = !v_s1 || adv;
	assign accept   = s_tvalid && s_tready;

	cde_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.step     (accept),
		.mode     (s_tdata[MW-1:0]),
		.req      (req),
		.res      (res)
	);

	cde_ram #(
		.DEPTH     (DEPTH),
		.WORD_WIDTH(WORD_WIDTH)
	) u_ram (
		.clk        (clk),
		.req        (req),
		.wdata      (s_tdata[MW +: WORD_WIDTH]),
		.rdata_front(rdata_front),
		.rdata_back (rdata_back)
	);

	// The memory returns old data when a read hits the slot written in the same
	// cycle, so the inserted word is carried along and substituted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1       <= res;
			fwd_front_s1 <= req.we && (req.waddr == req.raddr_front);
			fwd_back_s1  <= req.we && (req.waddr == req.raddr_back);
			wdata_s1     <= s_tdata[MW +: WORD_WIDTH];
		end
	end

	// An empty deque reports zero words whatever the slots hold.
	always_comb begin
		if (res_s1.count == '0) begin
			front_val = '0;
			back_val  = '0;
		end else begin
			front_val = fwd_front_s1 ? wdata_s1 : rdata_front;
			back_val  = fwd_back_s1 ? wdata_s1 : rdata_back;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q <= res_s1.status;
			front_q  <= front_val;
			back_q   <= back_val;
			count_q  <= res_s1.count;
		end
	end

	assign m_tvalid = out_v_q;

	always_comb begin
		m_tdata                                = '0;
		m_tdata[SW-1:0]                        = status_q;
		m_tdata[SW +: WORD_WIDTH]              = front_q;
		m_tdata[SW + WORD_WIDTH +: WORD_WIDTH] = back_q;
		m_tdata[SW + 2 * WORD_WIDTH +: CW]     = count_q;
		m_tdata[SW + 2 * WORD_WIDTH + CW]      = (count_q == '0);
	end

endmodule
